// File: rtl/wcpg_pkg.sv
`default_nettype none

package wcpg_pkg;

    // Chunk ids, read little-endian from the first four header bytes.
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Fixed lengths of the file layout.
    localparam logic [4:0] RIFF_HDR_LEN  = 5'd12;
    localparam logic [4:0] CHUNK_HDR_LEN = 5'd8;
    localparam logic [4:0] FMT_CAP_LEN   = 5'd16;

    // Sample clamp limits.
    localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
    localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

    // Gain after reset, about 0.8 in Q1.15.
    localparam logic [15:0] GAIN_RESET = 16'd26214;

    // Depth of the queue between parser and gain stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HEADER,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // One parsed word handed from the parser to the gain stage. When dual is
    // set the word stands for a format report followed by an end marker.
    typedef struct packed {
        kind_t        kind;
        logic         last;
        logic         dual;
        logic [15:0]  raw;
        logic [15:0]  format_tag;
        logic [15:0]  channels;
        logic [31:0]  sample_rate;
        logic [31:0]  byte_rate;
        logic [15:0]  block_align;
        logic [15:0]  bits_per_sample;
    } wcpg_entry_t;

endpackage

`default_nettype wire

// File: rtl/wcpg_front.sv
`default_nettype none

module wcpg_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte[7:0]
    input  wire logic                 s_tlast,   // end_of_file
    input  wire logic                 q_full,
    output logic                      push_valid,
    output wcpg_pkg::wcpg_entry_t     push_entry
);
    import wcpg_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [4:0]    byte_count_reg, byte_count_next;
    logic [63:0]   header_shift_reg, header_shift_next;
    logic [32:0]   chunk_remaining_reg, chunk_remaining_next;
    logic [15:0]   fmt_words_reg [8];
    logic [15:0]   fmt_words_next [8];
    logic [15:0]   fmt_upd [8];
    logic [8:0]    low_byte_reg, low_byte_next;

    logic          in_fire;
    logic          eof;
    logic [63:0]   hs_shift;
    logic          riff_done;
    logic          hdr_done;
    logic          is_data;
    logic          data_bad;
    logic [32:0]   pad_size;
    logic [32:0]   rem_dec;
    logic          data_end;
    logic          fmt_capture;
    logic [2:0]    fmt_idx;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;
    assign eof      = s_tlast;

    // Shared decode of the current byte.
    assign hs_shift    = {s_tdata, header_shift_reg[63:8]};
    assign riff_done   = (byte_count_reg == RIFF_HDR_LEN - 5'd1);
    assign hdr_done    = (byte_count_reg == CHUNK_HDR_LEN - 5'd1);
    assign is_data     = (hs_shift[31:0] == ID_DATA);
    assign data_bad    = (hs_shift[63:32] == 32'd0)
                         || ({fmt_words_reg[3], fmt_words_reg[2]} == 32'd0);
    assign pad_size    = ({1'b0, hs_shift[63:32]} + 33'd1) & ~33'd1;
    assign rem_dec     = chunk_remaining_reg - 33'd1;
    assign data_end    = (rem_dec == 33'd0) || eof;
    assign fmt_capture = (byte_count_reg < FMT_CAP_LEN)
                         && ({27'd0, byte_count_reg} < header_shift_reg[63:32]);
    assign fmt_idx     = byte_count_reg[3:1];

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    if (riff_done)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_done)
                    begin
                        if (is_data)
                        begin
                            phase_next = data_bad ? PH_DONE : PH_DATA;
                        end
                        else if (pad_size != 33'd0)
                        begin
                            phase_next = (hs_shift[31:0] == ID_FMT) ? PH_FMT : PH_SKIP;
                        end
                    end
                end
                PH_FMT, PH_SKIP:
                begin
                    if (rem_dec == 33'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_DATA:
                begin
                    if (data_end)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_RIFF;
                end
            endcase
            // The last byte of a file brings the parser back to its start.
            if (eof)
            begin
                phase_next = PH_RIFF;
            end
        end
    end

    // Format capture for a byte of a fmt body.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            fmt_upd[i] = fmt_words_reg[i];
        end
        if (in_fire && (phase_reg == PH_FMT) && fmt_capture)
        begin
            if (byte_count_reg[0])
            begin
                fmt_upd[fmt_idx] = {s_tdata, fmt_words_reg[fmt_idx][7:0]};
            end
            else
            begin
                fmt_upd[fmt_idx] = {fmt_words_reg[fmt_idx][15:8], s_tdata};
            end
        end
    end

    // Counters, header and result words.
    always_comb
    begin
        byte_count_next      = byte_count_reg;
        header_shift_next    = header_shift_reg;
        chunk_remaining_next = chunk_remaining_reg;
        low_byte_next        = low_byte_reg;
        push_valid           = 1'b0;
        push_entry.kind            = KIND_ERROR;
        push_entry.last            = 1'b1;
        push_entry.dual            = 1'b0;
        push_entry.raw             = 16'd0;
        push_entry.format_tag      = fmt_upd[0];
        push_entry.channels        = fmt_upd[1];
        push_entry.sample_rate     = {fmt_upd[3], fmt_upd[2]};
        push_entry.byte_rate       = {fmt_upd[5], fmt_upd[4]};
        push_entry.block_align     = fmt_upd[6];
        push_entry.bits_per_sample = fmt_upd[7];

        if (in_fire)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    byte_count_next = riff_done ? 5'd0 : byte_count_reg + 5'd1;
                    push_valid      = eof;
                end
                PH_HEADER:
                begin
                    header_shift_next = hs_shift;
                    if (!hdr_done)
                    begin
                        byte_count_next = byte_count_reg + 5'd1;
                        push_valid      = eof;
                    end
                    else
                    begin
                        byte_count_next = 5'd0;
                        if (!is_data)
                        begin
                            chunk_remaining_next = pad_size;
                            push_valid           = eof;
                        end
                        else if (data_bad)
                        begin
                            push_valid = 1'b1;
                        end
                        else
                        begin
                            // Format report, and an end marker too on the last byte.
                            chunk_remaining_next = {1'b0, hs_shift[63:32]};
                            low_byte_next        = 9'd0;
                            push_valid           = 1'b1;
                            push_entry.kind      = KIND_FORMAT;
                            push_entry.last      = eof;
                            push_entry.dual      = eof;
                        end
                    end
                end
                PH_FMT, PH_SKIP:
                begin
                    if ((phase_reg == PH_FMT) && (byte_count_reg < FMT_CAP_LEN))
                    begin
                        byte_count_next = byte_count_reg + 5'd1;
                    end
                    chunk_remaining_next = rem_dec;
                    if (rem_dec == 33'd0)
                    begin
                        byte_count_next = 5'd0;
                    end
                    push_valid = eof;
                end
                PH_DATA:
                begin
                    chunk_remaining_next = rem_dec;
                    if (low_byte_reg[8])
                    begin
                        push_valid      = 1'b1;
                        push_entry.kind = KIND_SAMPLE;
                        push_entry.raw  = {s_tdata, low_byte_reg[7:0]};
                        push_entry.last = data_end;
                        low_byte_next   = 9'd0;
                    end
                    else
                    begin
                        low_byte_next   = {1'b1, s_tdata};
                        push_valid      = data_end;
                        push_entry.kind = KIND_END;
                    end
                    if (data_end)
                    begin
                        low_byte_next = 9'd0;
                    end
                end
                PH_DONE:
                begin
                    push_valid = 1'b0;
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    // Format words, cleared at the end of each file.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            fmt_words_next[i] = (in_fire && eof) ? 16'd0 : fmt_upd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_RIFF;
            byte_count_reg      <= 5'd0;
            header_shift_reg    <= 64'd0;
            chunk_remaining_reg <= 33'd0;
            low_byte_reg        <= 9'd0;
            for (int i = 0; i < 8; i++)
            begin
                fmt_words_reg[i] <= 16'd0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            for (int i = 0; i < 8; i++)
            begin
                fmt_words_reg[i] <= fmt_words_next[i];
            end
            if (in_fire && eof)
            begin
                byte_count_reg      <= 5'd0;
                header_shift_reg    <= 64'd0;
                chunk_remaining_reg <= 33'd0;
                low_byte_reg        <= 9'd0;
            end
            else
            begin
                byte_count_reg      <= byte_count_next;
                header_shift_reg    <= header_shift_next;
                chunk_remaining_reg <= chunk_remaining_next;
                low_byte_reg        <= low_byte_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/wcpg_queue.sv
`default_nettype none

module wcpg_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    input  wire wcpg_pkg::wcpg_entry_t push_entry,
    output logic                       full,
    output logic                       head_valid,
    output wcpg_pkg::wcpg_entry_t      head_entry,
    input  wire logic                  pop
);
    import wcpg_pkg::*;

    wcpg_entry_t           slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wcpg_back.sv
`default_nettype none

module wcpg_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [15:0]           cfg_wr_data,
    input  wire logic                  head_valid,
    input  wire wcpg_pkg::wcpg_entry_t head_entry,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [143:0]               m_tdata,   // format_tag, channels, sample_rate,
                                                  // byte_rate, block_align,
                                                  // bits_per_sample, sample
    output logic [1:0]                 m_tuser,   // kind
    output logic                       m_tlast    // last
);
    import wcpg_pkg::*;

    logic [15:0]          gain_reg;
    logic                 half_reg, half_next;

    logic                 s1_valid_reg, s1_valid_next;
    wcpg_entry_t          s1_entry_reg, s1_entry_next;
    logic signed [32:0]   s1_prod_reg;

    logic                 out_valid_reg;
    wcpg_entry_t          out_entry_reg;
    logic [15:0]          out_sample_reg, out_sample_next;

    logic                 out_move;
    logic                 s1_take;
    logic                 issue;
    logic signed [33:0]   biased;
    logic signed [18:0]   quot;

    // Gain register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            gain_reg <= cfg_wr_data;
        end
    end

    // Flow control through the multiply stage and the output register.
    assign out_move = !out_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || out_move;
    assign issue    = head_valid && s1_take;

    // Issue from the queue head; a dual word issues twice before it pops.
    always_comb
    begin
        s1_entry_next = head_entry;
        half_next     = half_reg;
        pop           = 1'b0;
        if (issue)
        begin
            if (head_entry.dual && !half_reg)
            begin
                s1_entry_next.kind = KIND_FORMAT;
                s1_entry_next.last = 1'b0;
                half_next          = 1'b1;
            end
            else
            begin
                if (head_entry.dual)
                begin
                    s1_entry_next.kind = KIND_END;
                    s1_entry_next.last = 1'b1;
                end
                half_next = 1'b0;
                pop       = 1'b1;
            end
        end
        s1_valid_next = s1_take ? issue : s1_valid_reg;
    end

    // Truncate toward zero, then clamp.
    assign biased = {s1_prod_reg[32], s1_prod_reg}
                    + (s1_prod_reg[32] ? 34'sd32767 : 34'sd0);
    assign quot   = biased[33:15];

    always_comb
    begin
        if (quot > SAMPLE_MAX)
        begin
            out_sample_next = SAMPLE_MAX[15:0];
        end
        else if (quot < SAMPLE_MIN)
        begin
            out_sample_next = SAMPLE_MIN[15:0];
        end
        else
        begin
            out_sample_next = quot[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            half_reg     <= half_next;
            s1_valid_reg <= s1_valid_next;
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_entry_reg <= s1_entry_next;
            s1_prod_reg  <= $signed(head_entry.raw) * $signed({1'b0, gain_reg});
        end
        if (out_move && s1_valid_reg)
        begin
            out_entry_reg  <= s1_entry_reg;
            out_sample_reg <= out_sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_entry_reg.kind;
    assign m_tlast  = out_entry_reg.last;
    assign m_tdata  = {out_sample_reg,
                       out_entry_reg.bits_per_sample,
                       out_entry_reg.block_align,
                       out_entry_reg.byte_rate,
                       out_entry_reg.sample_rate,
                       out_entry_reg.channels,
                       out_entry_reg.format_tag};

`ifndef SYNTHESIS
    // Only a sample word carries a nonzero sample.
    a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != KIND_SAMPLE)) |-> (m_tdata[143:128] == 16'd0))
        else $error("nonzero sample on a non-sample word");

    // The second half of a dual word is pending only while that word heads the queue.
    a_half_head: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (head_valid && head_entry.dual))
        else $error("dual word lost its head slot");

    // Issuing the second half always pops and clears the half flag.
    a_half_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (half_reg && issue) |-> (pop ##1 !half_reg))
        else $error("dual word not retired after its second half");

    // A word that reaches the output as a report from a dual word is never marked last.
    a_format_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && head_entry.dual && !half_reg) |=> (s1_entry_reg.kind == KIND_FORMAT
                                                     && !s1_entry_reg.last))
        else $error("format half of a dual word is mislabeled");
`endif

endmodule

`default_nettype wire

// File: rtl/wav_chunk_parse_and_gain.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tdata: data_byte; s_tlast: end_of_file
// m_*       out  m_tvalid / m_tready  m_tdata: format and sample; m_tuser: kind;
//                                     m_tlast: last
// cfg_*     in   cfg_wr_en            cfg_wr_data: volume_gain
//
// One file byte is taken per cycle while the four-word queue has room.
// Results pass through the queue, the multiply stage and the output register.
// A format report that coincides with end of file leaves as two words: the report, then an end marker.
// Reset is asynchronous and active low; the gain returns to 26214 and parsing restarts.
// The output stalls back through the gain stage and the queue to s_tready.
`default_nettype none

module wav_chunk_parse_and_gain (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte[7:0]
    input  wire logic          s_tlast,   // end_of_file
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [143:0]       m_tdata,   // format_tag[15:0], channels[31:16],
                                          // sample_rate[63:32], byte_rate[95:64],
                                          // block_align[111:96],
                                          // bits_per_sample[127:112], sample[143:128]
    output logic [1:0]         m_tuser,   // kind[1:0]
    output logic               m_tlast,   // last
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data
);
    import wcpg_pkg::*;

    logic          push_valid;
    wcpg_entry_t   push_entry;
    logic          q_full;
    logic          head_valid;
    wcpg_entry_t   head_entry;
    logic          pop;

    // Parser: header walk and format capture.
    wcpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // Short queue of parsed words.
    wcpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Gain, clamp and output register.
    wcpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
